// ===== rtl/bcmf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcmf_pkg: shared types, constants and tables of the beam/cell measurement filter
// Holds the field widths, the conversion and filter-weight tables, and the
// command and status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bcmf_pkg;

    // Field and storage widths.
    localparam int MAX_BEAMS  = 64;
    localparam int BEAM_W     = 6;
    localparam int SLOT_W     = 7;
    localparam int MAX_AVG    = 32;
    localparam int AVG_W      = 6;
    localparam int QC_W       = 7;
    localparam int POWER_W    = 56;
    localparam int OUT_W      = 52;
    localparam int SUM_W      = POWER_W + AVG_W;
    localparam int DB_W       = 13;
    localparam int X_W        = 12;
    localparam int Q_W        = 4;
    localparam int R_W        = 8;
    localparam int K_W        = 5;
    localparam int ALPHA_W    = 17;
    localparam int CNT_W      = 6;

    localparam logic signed [DB_W-1:0] DB_MIN = -13'sd2560;
    localparam logic signed [DB_W-1:0] DB_MAX = -13'sd480;
    localparam logic [K_W-1:0] K_MAX = 5'd19;
    localparam logic [QC_W-1:0] QC_MAX = 7'd127;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SUM_W - 1);

    // Configuration register file seen by the datapath.
    typedef struct packed {
        logic [K_W-1:0]           coeff_index;
        logic signed [DB_W-1:0]   threshold_db;
        logic [AVG_W-1:0]         max_avg;
        logic [SLOT_W-1:0]        beams_in_use;
    } t_cfg;

    // Commands from the controller, one strobe per datapath step.
    typedef struct packed {
        logic load;
        logic conv1;
        logic conv2;
        logic conv3;
        logic conv4;
        logic fa;
        logic fb;
        logic fc;
        logic fd;
        logic sel_cell;
        logic upd;
        logic setn;
        logic sum_step;
        logic div_init;
        logic div_step;
        logic cell_load;
        logic slot_end;
        logic apply_cell;
        logic out_load;
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        logic beams_started;
        logic cell_started;
        logic slot_done;
        logic n_zero;
        logic sum_done;
        logic div_last;
        logic out_busy;
    } t_stat;

    // Whole-decibel steps, 10^(d/10) in Q28.
    function automatic logic [31:0] dec_tab(input logic [3:0] d);
        logic [31:0] v;
        case (d)
            4'd0:    v = 32'd268435456;
            4'd1:    v = 32'd337940217;
            4'd2:    v = 32'd425441527;
            4'd3:    v = 32'd535599149;
            4'd4:    v = 32'd674279380;
            4'd5:    v = 32'd848867446;
            4'd6:    v = 32'd1068660799;
            4'd7:    v = 32'd1345364236;
            4'd8:    v = 32'd1693713225;
            4'd9:    v = 32'd2132258619;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Sixteenth-decibel steps, 10^(f/160) in Q28.
    function automatic logic [31:0] sub_tab(input logic [3:0] f);
        logic [31:0] v;
        case (f)
            4'd0:    v = 32'd268435456;
            4'd1:    v = 32'd272326484;
            4'd2:    v = 32'd276273913;
            4'd3:    v = 32'd280278561;
            4'd4:    v = 32'd284341257;
            4'd5:    v = 32'd288462842;
            4'd6:    v = 32'd292644171;
            4'd7:    v = 32'd296886109;
            4'd8:    v = 32'd301189535;
            4'd9:    v = 32'd305555340;
            4'd10:   v = 32'd309984429;
            4'd11:   v = 32'd314477717;
            4'd12:   v = 32'd319036137;
            4'd13:   v = 32'd323660633;
            4'd14:   v = 32'd328352161;
            default: v = 32'd333111694;
        endcase
        return v;
    endfunction

    // Filter weight 2^(-k/4) in Q16.
    function automatic logic [ALPHA_W-1:0] alpha_tab(input logic [K_W-1:0] k);
        logic [ALPHA_W-1:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd55109;
            5'd2:    v = 17'd46341;
            5'd3:    v = 17'd38968;
            5'd4:    v = 17'd32768;
            5'd5:    v = 17'd27554;
            5'd6:    v = 17'd23170;
            5'd7:    v = 17'd19484;
            5'd8:    v = 17'd16384;
            5'd9:    v = 17'd13777;
            5'd10:   v = 17'd11585;
            5'd11:   v = 17'd9742;
            5'd12:   v = 17'd8192;
            5'd13:   v = 17'd6889;
            5'd14:   v = 17'd5793;
            5'd15:   v = 17'd4871;
            5'd16:   v = 17'd4096;
            5'd17:   v = 17'd3444;
            5'd18:   v = 17'd2896;
            default: v = 17'd2435;
        endcase
        return v;
    endfunction

    // Powers of five for the ten-decibel decades.
    function automatic logic [31:0] pow5(input logic [Q_W-1:0] q);
        logic [31:0] v;
        case (q)
            4'd0:    v = 32'd1;
            4'd1:    v = 32'd5;
            4'd2:    v = 32'd25;
            4'd3:    v = 32'd125;
            4'd4:    v = 32'd625;
            4'd5:    v = 32'd3125;
            4'd6:    v = 32'd15625;
            4'd7:    v = 32'd78125;
            4'd8:    v = 32'd390625;
            4'd9:    v = 32'd1953125;
            4'd10:   v = 32'd9765625;
            4'd11:   v = 32'd48828125;
            4'd12:   v = 32'd244140625;
            default: v = 32'd1220703125;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/beam_cell_measurement_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// beam_cell_measurement_filter: layer-3 beam and cell power filter
// Converts beam power to linear, filters each beam estimate, keeps the
// strongest qualifying beams and filters their average into the cell value.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word
//  s_axis   in         tdata = beam_index, rsrp_db
//  m_axis   out        tdata = beam_number, beam_filtered, cell_filtered;
//                      tlast = slot_done; tuser = no_qualifying_beam
//  apb      in/out     four 32-bit registers at byte addresses 0, 4, 8, 12
//
// A beam word passes the four conversion steps, the four-step filter (skipped
// in the first slot) and the update before its result is loaded.
// A slot's last word adds N summing steps over the top list, the 62-step
// one-bit-per-cycle divider and the cell pass through the filter; the cell
// estimate is loaded directly the first time, and none of these run when no beam qualifies.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result sits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module beam_cell_measurement_filter import bcmf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // beam_index[5:0], rsrp_db[18:6], zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // beam_number[5:0], beam_filtered[57:6],
                                         // cell_filtered[109:58], zero pad
    output logic         m_axis_tlast,
    output logic         m_axis_tuser,   // no_qualifying_beam
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [1:0] REG_COEFF = 2'd0;
    localparam logic [1:0] REG_THR   = 2'd1;
    localparam logic [1:0] REG_NAVG  = 2'd2;
    localparam logic [1:0] REG_BEAMS = 2'd3;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    logic [BEAM_W-1:0] o_beam_number;
    logic [OUT_W-1:0]  o_beam_filtered;
    logic [OUT_W-1:0]  o_cell_filtered;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coeff_index  <= K_W'(4);
            r_cfg.threshold_db <= DB_MIN;
            r_cfg.max_avg      <= AVG_W'(1);
            r_cfg.beams_in_use <= SLOT_W'(8);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_COEFF: r_cfg.coeff_index  <= pwdata[K_W-1:0];
                REG_THR:   r_cfg.threshold_db <= pwdata[DB_W-1:0];
                REG_NAVG:  r_cfg.max_avg      <= pwdata[AVG_W-1:0];
                REG_BEAMS: r_cfg.beams_in_use <= pwdata[SLOT_W-1:0];
                default:   r_cfg.coeff_index  <= r_cfg.coeff_index;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (paddr[3:2])
            REG_COEFF: prdata = 32'(r_cfg.coeff_index);
            REG_THR:   prdata = {{(32-DB_W){r_cfg.threshold_db[DB_W-1]}},
                                 r_cfg.threshold_db};
            REG_NAVG:  prdata = 32'(r_cfg.max_avg);
            REG_BEAMS: prdata = 32'(r_cfg.beams_in_use);
            default:   prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    bcmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bcmf_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_beam_index    (s_axis_tdata[5:0]),
        .i_rsrp_db       (s_axis_tdata[18:6]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_beam_number   (o_beam_number),
        .o_beam_filtered (o_beam_filtered),
        .o_cell_filtered (o_cell_filtered),
        .o_slot_done     (m_axis_tlast),
        .o_no_qual       (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, o_cell_filtered, o_beam_filtered, o_beam_number};

`ifndef NO_ASSERTIONS
    // One word in flight: an accepted word closes the input for the next cycle.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a word was in flight");

    // The no-qualifying-beam flag only comes with a slot's last word.
    a_flag_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("no-qualifying-beam flag outside slot end");
`endif

endmodule
`default_nettype wire

// ===== rtl/bcmf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcmf_ctrl: sequencer of the beam/cell measurement filter
// Steps the datapath through conversion, beam filtering, top-N update and,
// at a slot's last beam, summing, division and cell filtering.
// ----------------------------------------------------------------------------
module bcmf_ctrl import bcmf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CONV1 = 5'd1;
    localparam logic [4:0] ST_CONV2 = 5'd2;
    localparam logic [4:0] ST_CONV3 = 5'd3;
    localparam logic [4:0] ST_CONV4 = 5'd4;
    localparam logic [4:0] ST_FA    = 5'd5;
    localparam logic [4:0] ST_FB    = 5'd6;
    localparam logic [4:0] ST_FC    = 5'd7;
    localparam logic [4:0] ST_FD    = 5'd8;
    localparam logic [4:0] ST_UPD   = 5'd9;
    localparam logic [4:0] ST_SETN  = 5'd10;
    localparam logic [4:0] ST_SUM   = 5'd11;
    localparam logic [4:0] ST_DIV   = 5'd12;
    localparam logic [4:0] ST_CELL  = 5'd13;
    localparam logic [4:0] ST_SEND  = 5'd14;
    localparam logic [4:0] ST_FIN   = 5'd15;

    logic [4:0] r_state, n_state;
    logic       r_cell, n_cell;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cell  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cell  <= n_cell;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_cell  = r_cell;
        o_cmd   = '0;
        o_cmd.sel_cell   = r_cell;
        o_cmd.apply_cell = r_cell;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cell     = 1'b0;
                    n_state    = ST_CONV1;
                end
            end
            ST_CONV1: begin
                o_cmd.conv1 = 1'b1;
                n_state     = ST_CONV2;
            end
            ST_CONV2: begin
                o_cmd.conv2 = 1'b1;
                n_state     = ST_CONV3;
            end
            ST_CONV3: begin
                o_cmd.conv3 = 1'b1;
                n_state     = ST_CONV4;
            end
            ST_CONV4: begin
                o_cmd.conv4 = 1'b1;
                n_state     = i_stat.beams_started ? ST_FA : ST_UPD;
            end
            ST_FA: begin
                o_cmd.fa = 1'b1;
                n_state  = ST_FB;
            end
            ST_FB: begin
                o_cmd.fb = 1'b1;
                n_state  = ST_FC;
            end
            ST_FC: begin
                o_cmd.fc = 1'b1;
                n_state  = ST_FD;
            end
            ST_FD: begin
                o_cmd.fd = 1'b1;
                n_state  = r_cell ? ST_SEND : ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_stat.slot_done ? ST_SETN : ST_FIN;
            end
            ST_SETN: begin
                o_cmd.setn = 1'b1;
                n_state    = ST_SUM;
            end
            ST_SUM: begin
                if (!i_stat.sum_done) begin
                    o_cmd.sum_step = 1'b1;
                end else if (i_stat.n_zero) begin
                    n_state = ST_SEND;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_CELL;
                end
            end
            ST_CELL: begin
                // First average loads the cell estimate; later ones are filtered.
                if (i_stat.cell_started) begin
                    n_cell  = 1'b1;
                    n_state = ST_FA;
                end else begin
                    o_cmd.cell_load = 1'b1;
                    n_state         = ST_SEND;
                end
            end
            ST_SEND: begin
                o_cmd.slot_end = 1'b1;
                n_state        = ST_FIN;
            end
            ST_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/bcmf_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcmf_dpath: datapath of the beam/cell measurement filter
// Power conversion, beam estimate memory, shared first-order filter, top-N
// list, accumulator and bit-serial divider, and the output word register.
// ----------------------------------------------------------------------------
module bcmf_dpath import bcmf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [BEAM_W-1:0]      i_beam_index,
    input  logic signed [DB_W-1:0] i_rsrp_db,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [BEAM_W-1:0]      o_beam_number,
    output logic [OUT_W-1:0]       o_beam_filtered,
    output logic [OUT_W-1:0]       o_cell_filtered,
    output logic                   o_slot_done,
    output logic                   o_no_qual
);

    // Beam estimate memory, undefined until written.
    logic [POWER_W-1:0] mem [MAX_BEAMS];
    logic [POWER_W-1:0] r_rd;

    logic [BEAM_W-1:0]  r_idx;
    logic [X_W-1:0]     r_x;
    logic               r_qual;
    logic               r_done;
    logic [Q_W-1:0]     r_q;
    logic [R_W-1:0]     r_r;
    logic [63:0]        r_p;
    logic [63:0]        r_prod;
    logic [POWER_W-1:0] r_mres;

    logic [POWER_W-1:0] r_ff;
    logic [POWER_W-1:0] r_mag;
    logic               r_dir;
    logic [ALPHA_W+39:0] r_hi;
    logic [ALPHA_W+40:0] r_step;
    logic [POWER_W-1:0] r_fres;
    logic [POWER_W-1:0] r_bout;

    logic               r_bst;
    logic               r_cst;
    logic [QC_W-1:0]    r_qc;
    logic [POWER_W-1:0] r_top [MAX_AVG];
    logic [POWER_W-1:0] r_cell_est;
    logic [AVG_W-1:0]   r_n;
    logic [SUM_W-1:0]   r_quo;
    logic [AVG_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_none;

    logic               r_ovalid;
    logic [BEAM_W-1:0]  r_o_idx;
    logic [OUT_W-1:0]   r_o_beam;
    logic [OUT_W-1:0]   r_o_cell;
    logic               r_o_done;
    logic               r_o_none;

    // Input clamp, offset and slot-end decode.
    logic signed [DB_W-1:0] db_c;
    logic signed [DB_W:0]   xs;
    logic [SLOT_W-1:0]      slot_len;
    always_comb begin
        if (i_rsrp_db < DB_MIN) begin
            db_c = DB_MIN;
        end else if (i_rsrp_db > DB_MAX) begin
            db_c = DB_MAX;
        end else begin
            db_c = i_rsrp_db;
        end
        xs = {db_c[DB_W-1], db_c} - {DB_MIN[DB_W-1], DB_MIN};
        if (i_cfg.beams_in_use == '0) begin
            slot_len = SLOT_W'(1);
        end else if (i_cfg.beams_in_use > SLOT_W'(MAX_BEAMS)) begin
            slot_len = SLOT_W'(MAX_BEAMS);
        end else begin
            slot_len = i_cfg.beams_in_use;
        end
    end

    // Split x into decades of 160 by reciprocal multiply and one correction.
    logic [20:0]   x_recip;
    logic [Q_W-1:0] q0;
    logic [11:0]   q0x;
    logic [12:0]   r0;
    always_comb begin
        x_recip = 21'(r_x) * 21'd410;
        q0      = x_recip[Q_W+15:16];
        q0x     = 12'(q0) * 12'd160;
        r0      = {1'b0, r_x} - {1'b0, q0x};
    end

    // Linear scaling of the mantissa.
    logic [31:0] m_lin;
    logic [63:0] p_rnd;
    logic [4:0]  sh;
    logic [63:0] prod_rnd;
    always_comb begin
        p_rnd    = r_p + 64'd134217728;
        m_lin    = p_rnd[59:28];
        sh       = 5'd20 - 5'(r_q);
        prod_rnd = r_prod + (64'd1 << (sh - 5'd1));
    end

    // Shared filter operands.
    logic [POWER_W-1:0] f_in;
    logic [POWER_W-1:0] m_in;
    logic [K_W-1:0]     kc;
    logic [ALPHA_W-1:0] alpha;
    logic [32:0]        lo_prod;
    logic [33:0]        lo_rnd;
    always_comb begin
        f_in    = i_cmd.sel_cell ? r_cell_est : r_rd;
        m_in    = i_cmd.sel_cell ? r_quo[POWER_W-1:0] : r_mres;
        kc      = (i_cfg.coeff_index > K_MAX) ? K_MAX : i_cfg.coeff_index;
        alpha   = alpha_tab(kc);
        lo_prod = 33'(alpha) * 33'(r_mag[15:0]);
        lo_rnd  = 34'(lo_prod) + 34'd32768;
    end

    // Top-N insertion: every slot but the first looks at its own entry and its upper neighbor.
    logic [MAX_AVG-1:0] ge;
    logic [POWER_W-1:0] ins [MAX_AVG];
    always_comb begin
        for (int j = 0; j < MAX_AVG; j++) begin
            ge[j] = (r_top[j] >= r_mres);
        end
        ins[0] = ge[0] ? r_top[0] : r_mres;
        for (int j = 1; j < MAX_AVG; j++) begin
            if (ge[j]) begin
                ins[j] = r_top[j];
            end else if (ge[j-1]) begin
                ins[j] = r_mres;
            end else begin
                ins[j] = r_top[j-1];
            end
        end
    end

    // Averaging count, clamped and limited to the qualifying beams.
    logic [AVG_W-1:0]   n_clamp;
    logic [POWER_W-1:0] w_beam;
    logic [AVG_W:0]     div_t;
    always_comb begin
        if (i_cfg.max_avg == '0) begin
            n_clamp = AVG_W'(1);
        end else if (i_cfg.max_avg > AVG_W'(MAX_AVG)) begin
            n_clamp = AVG_W'(MAX_AVG);
        end else begin
            n_clamp = i_cfg.max_avg;
        end
        w_beam = r_bst ? r_fres : r_mres;
        div_t  = {r_rem, r_quo[SUM_W-1]};
    end

    // Memory port: registered read on load, write on update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= mem[i_beam_index];
        end
        if (i_cmd.upd) begin
            mem[r_idx] <= w_beam;
        end
    end

    // Payload registers of the conversion, filter and divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx  <= i_beam_index;
            r_x    <= xs[X_W-1:0];
            r_qual <= (db_c > i_cfg.threshold_db);
            r_done <= ({1'b0, i_beam_index} == (slot_len - SLOT_W'(1)));
        end
        if (i_cmd.conv1) begin
            if (r0[12]) begin
                r_q <= q0 - Q_W'(1);
                r_r <= R_W'(r0 + 13'd160);
            end else begin
                r_q <= q0;
                r_r <= r0[R_W-1:0];
            end
        end
        if (i_cmd.conv2) begin
            r_p <= 64'(dec_tab(r_r[7:4])) * 64'(sub_tab(r_r[3:0]));
        end
        if (i_cmd.conv3) begin
            r_prod <= 64'(m_lin) * 64'(pow5(r_q));
        end
        if (i_cmd.conv4) begin
            r_mres <= POWER_W'(prod_rnd >> sh);
        end
        if (i_cmd.fa) begin
            r_ff  <= f_in;
            r_dir <= (m_in >= f_in);
            r_mag <= (m_in >= f_in) ? (m_in - f_in) : (f_in - m_in);
        end
        if (i_cmd.fb) begin
            r_hi <= (ALPHA_W+40)'(alpha) * (ALPHA_W+40)'(r_mag[POWER_W-1:16]);
        end
        if (i_cmd.fc) begin
            r_step <= (ALPHA_W+41)'(r_hi) + (ALPHA_W+41)'(lo_rnd[33:16]);
        end
        if (i_cmd.fd) begin
            r_fres <= r_dir ? (r_ff + r_step[POWER_W-1:0])
                            : (r_ff - r_step[POWER_W-1:0]);
        end
        if (i_cmd.upd) begin
            r_bout <= w_beam;
        end
        if (i_cmd.setn) begin
            r_n <= (r_qc < QC_W'(n_clamp)) ? r_qc[AVG_W-1:0] : n_clamp;
        end
        if (i_cmd.setn) begin
            r_quo <= '0;
            r_cnt <= '0;
        end else if (i_cmd.sum_step) begin
            r_quo <= r_quo + SUM_W'(r_top[0]);
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_cmd.div_init) begin
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            // One restoring-division bit per cycle.
            if (div_t >= {1'b0, r_n}) begin
                r_rem <= AVG_W'(div_t - {1'b0, r_n});
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= div_t[AVG_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.load) begin
            r_none <= 1'b0;
        end else if (i_cmd.slot_end) begin
            r_none <= (r_n == '0);
        end
        if (i_cmd.out_load) begin
            r_o_idx  <= r_idx;
            r_o_beam <= r_bout[OUT_W-1:0];
            r_o_cell <= r_cell_est[OUT_W-1:0];
            r_o_done <= r_done;
            r_o_none <= r_none;
        end
    end

    // State with defined reset: flags, count, top list, cell estimate, valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst      <= 1'b0;
            r_cst      <= 1'b0;
            r_qc       <= '0;
            r_cell_est <= '0;
            r_ovalid   <= 1'b0;
            for (int j = 0; j < MAX_AVG; j++) begin
                r_top[j] <= '0;
            end
        end else begin
            if (i_cmd.upd && r_qual) begin
                for (int j = 0; j < MAX_AVG; j++) begin
                    r_top[j] <= ins[j];
                end
                if (r_qc != QC_MAX) begin
                    r_qc <= r_qc + QC_W'(1);
                end
            end else if (i_cmd.sum_step) begin
                for (int j = 0; j < MAX_AVG - 1; j++) begin
                    r_top[j] <= r_top[j+1];
                end
                r_top[MAX_AVG-1] <= '0;
            end else if (i_cmd.slot_end) begin
                for (int j = 0; j < MAX_AVG; j++) begin
                    r_top[j] <= '0;
                end
                r_qc <= '0;
            end
            if (i_cmd.slot_end) begin
                r_bst <= 1'b1;
            end
            if (i_cmd.cell_load) begin
                r_cell_est <= r_quo[POWER_W-1:0];
                r_cst      <= 1'b1;
            end else if (i_cmd.slot_end && i_cmd.apply_cell) begin
                r_cell_est <= r_fres;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.beams_started = r_bst;
        o_stat.cell_started  = r_cst;
        o_stat.slot_done     = r_done;
        o_stat.n_zero        = (r_n == '0);
        o_stat.sum_done      = (r_cnt == CNT_W'(r_n));
        o_stat.div_last      = (r_cnt == DIV_LAST);
        o_stat.out_busy      = r_ovalid && !i_out_ready;
    end

    assign o_out_valid     = r_ovalid;
    assign o_beam_number   = r_o_idx;
    assign o_beam_filtered = r_o_beam;
    assign o_cell_filtered = r_o_cell;
    assign o_slot_done     = r_o_done;
    assign o_no_qual       = r_o_none;

endmodule
`default_nettype wire

// ===== sim/beam_cell_measurement_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beam_cell_measurement_filter_test: self-checking bench for the beam/cell filter
// Streams beam power words through the filter under random gaps on both
// sides, predicts every beam and cell estimate in fixed point, and compares
// each result word field by field. Registers are rewritten between phases.
// ----------------------------------------------------------------------------
module beam_cell_measurement_filter_test;
    import bcmf_pkg::*;

    localparam logic [3:0] REG_COEFF = 4'd0;
    localparam logic [3:0] REG_THRESH = 4'd4;
    localparam logic [3:0] REG_NAVG = 4'd8;
    localparam logic [3:0] REG_SLOT = 4'd12;

    typedef struct packed {
        logic [5:0]  beam;
        logic [51:0] beam_pow;
        logic [51:0] cell_pow;
        logic        done;
        logic        none;
    } t_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata;   // beam_index[5:0], rsrp_db[18:6], zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // beam_number[5:0], beam_filtered[57:6],
                                  // cell_filtered[109:58], zero pad
    logic         m_axis_tlast;
    logic         m_axis_tuser;   // no_qualifying_beam
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    beam_cell_measurement_filter u_dut (.*);

    // Predictor state.
    logic [4:0]        pr_coeff;
    logic signed [12:0] pr_thresh;
    logic [5:0]        pr_navg;
    logic [6:0]        pr_slot;
    logic [55:0]       est_beam [64];
    logic              est_started;
    logic [55:0]       top_list [32];
    int unsigned       qual_count;
    logic [55:0]       est_cell;
    logic              cell_started;

    logic [23:0] word_queue[$];
    t_result     result_queue[$];
    int          err_count;
    int          hold_rx;
    int          gap_tx;
    bit          tx_pause;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("beam_cell_measurement_filter_test: errors");
        $finish;
    end

    function automatic logic [55:0] db_to_linear(input logic signed [12:0] db_in);
        int          db;
        int unsigned x, q, r, sh;
        logic [63:0] p, m, p5;
        db = db_in;
        if (db < -2560) db = -2560;
        if (db > -480) db = -480;
        x = db + 2560;
        q = x / 160;
        r = x % 160;
        p = 64'(dec_tab(4'(r / 16))) * 64'(sub_tab(4'(r % 16)));
        m = (p + (64'd1 << 27)) >> 28;
        p5 = 1;
        for (int i = 0; i < q; i++) p5 = p5 * 5;
        sh = 20 - q;
        return 56'((m * p5 + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic logic [55:0] smooth_toward(input logic [55:0] f,
                                                  input logic [55:0] m,
                                                  input logic [16:0] a);
        logic [127:0] mag, stp;
        mag = (m >= f) ? 128'(m - f) : 128'(f - m);
        stp = (128'(a) * mag + 128'd32768) >> 16;
        return (m >= f) ? 56'(f + stp) : 56'(f - stp);
    endfunction

    // Computes the result word that one beam measurement causes.
    task automatic predict_measurement(input logic [23:0] w);
        logic [5:0]         idx;
        int                 db;
        logic [55:0]        m;
        logic [16:0]        a;
        int unsigned        slen, n, pos;
        logic [61:0]        sum;
        t_result            res;
        idx = w[5:0];
        db = $signed(w[18:6]);
        if (db < -2560) db = -2560;
        if (db > -480) db = -480;
        m = db_to_linear(13'(db));
        a = alpha_tab((pr_coeff > 5'd19) ? 5'd19 : pr_coeff);
        slen = (pr_slot < 1) ? 1 : (pr_slot > 64 ? 64 : pr_slot);
        res.none = 1'b0;
        est_beam[idx] = est_started ? smooth_toward(est_beam[idx], m, a) : m;
        if (db > int'(pr_thresh)) begin
            pos = (qual_count < 32) ? qual_count : 32;
            if (!(pos == 32 && m <= top_list[31])) begin
                if (pos == 32) pos = 31;
                while (pos > 0 && top_list[pos-1] < m) begin
                    top_list[pos] = top_list[pos-1];
                    pos--;
                end
                top_list[pos] = m;
            end
            if (qual_count < 127) qual_count++;
        end
        res.done = (idx == slen - 1);
        if (res.done) begin
            n = (pr_navg < 1) ? 1 : (pr_navg > 32 ? 32 : pr_navg);
            if (n > qual_count) n = qual_count;
            if (n == 0) begin
                res.none = 1'b1;
            end else begin
                sum = 0;
                for (int i = 0; i < n; i++) sum += top_list[i];
                sum = sum / n;
                if (!cell_started) begin
                    est_cell = 56'(sum);
                    cell_started = 1'b1;
                end else begin
                    est_cell = smooth_toward(est_cell, 56'(sum), a);
                end
            end
            for (int i = 0; i < 32; i++) top_list[i] = '0;
            qual_count = 0;
            est_started = 1'b1;
        end
        res.beam = idx;
        res.beam_pow = est_beam[idx][51:0];
        res.cell_pow = est_cell[51:0];
        result_queue.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Driver: feeds words from the pending queue with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_tx <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) predict_measurement(s_axis_tdata);
            if (gap_tx > 0) begin
                gap_tx <= gap_tx - 1;
                s_axis_tvalid <= 1'b0;
            end else if (word_queue.size() > 0 && !tx_pause) begin
                s_axis_tdata <= word_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                gap_tx <= ($urandom_range(0, 9) < 6) ? 0 :
                          (($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(1, 4));
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result word and drives random back-pressure.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_queue.size() == 0) begin
                    report_mismatch("unexpected word", 64'(m_axis_tdata[5:0]), 0);
                end else begin
                    want = result_queue.pop_front();
                    if (m_axis_tdata[5:0] != want.beam)
                        report_mismatch("beam_number", m_axis_tdata[5:0], want.beam);
                    if (m_axis_tdata[57:6] != want.beam_pow)
                        report_mismatch("beam_filtered", m_axis_tdata[57:6], want.beam_pow);
                    if (m_axis_tdata[109:58] != want.cell_pow)
                        report_mismatch("cell_filtered", m_axis_tdata[109:58],
                                        want.cell_pow);
                    if (m_axis_tlast != want.done)
                        report_mismatch("slot_done", m_axis_tlast, want.done);
                    if (m_axis_tuser != want.none)
                        report_mismatch("no_qualifying_beam", m_axis_tuser, want.none);
                end
            end
            if (hold_rx > 0) begin
                hold_rx <= hold_rx - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 9) < 7);
                if ($urandom_range(0, 99) == 0) hold_rx <= $urandom_range(5, 40);
            end
        end
    end

    task automatic reg_write(input logic [3:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (addr)
            REG_COEFF:  pr_coeff = value[4:0];
            REG_THRESH: pr_thresh = value[12:0];
            REG_NAVG:   pr_navg = value[5:0];
            REG_SLOT:   pr_slot = value[6:0];
            default: ;
        endcase
    endtask

    // Waits until every queued word is sent and every result has arrived.
    task automatic drain_all();
        while (word_queue.size() > 0 || s_axis_tvalid || result_queue.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pack_word(input int beam, input int db);
        return {5'd0, 13'(db), 6'(beam)};
    endfunction

    // One slot of beams 0..len-1, random powers, an occasional raw extreme.
    task automatic queue_slot(input int len);
        int db;
        for (int b = 0; b < len; b++) begin
            case ($urandom_range(0, 15))
                0: db = $urandom_range(0, 8191) - 4096;
                1: db = -2560;
                2: db = -480;
                default: db = -2560 + $urandom_range(0, 2080);
            endcase
            word_queue.push_back(pack_word(b, db));
        end
    endtask

    initial begin
        int slen;
        err_count = 0;
        hold_rx = 0;
        tx_pause = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        pr_coeff = 5'd4; pr_thresh = -13'sd2560; pr_navg = 6'd1; pr_slot = 7'd8;
        for (int i = 0; i < 64; i++) est_beam[i] = '0;
        for (int i = 0; i < 32; i++) top_list[i] = '0;
        est_started = 1'b0; qual_count = 0; est_cell = '0; cell_started = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First slot covers every beam so no estimate is ever read unwritten.
        reg_write(REG_SLOT, 32'd64);
        reg_write(REG_COEFF, 32'd0);
        queue_slot(64);
        drain_all();

        // Directed: extremes, out-of-range powers and an empty slot.
        reg_write(REG_SLOT, 32'd4);
        reg_write(REG_THRESH, 32'h1fff & -32'sd480);
        reg_write(REG_COEFF, 32'd19);
        word_queue.push_back(pack_word(0, -2560));
        word_queue.push_back(pack_word(1, -480));
        word_queue.push_back(pack_word(2, -4096));
        word_queue.push_back(pack_word(3, 4095));
        drain_all();
        reg_write(REG_THRESH, 32'h1fff & -32'sd2560);
        reg_write(REG_NAVG, 32'd32);
        word_queue.push_back(pack_word(0, -481));
        word_queue.push_back(pack_word(1, -2559));
        word_queue.push_back(pack_word(2, -1000));
        word_queue.push_back(pack_word(3, -2560));
        drain_all();
        // Out-of-range register values: zero slot length, zero and large counts.
        reg_write(REG_SLOT, 32'd0);
        reg_write(REG_NAVG, 32'd0);
        reg_write(REG_COEFF, 32'd31);
        word_queue.push_back(pack_word(0, -900));
        word_queue.push_back(pack_word(0, -700));
        drain_all();
        reg_write(REG_SLOT, 32'd127);
        reg_write(REG_NAVG, 32'd63);
        queue_slot(64);
        drain_all();

        // Long receiver hold while the sender keeps offering words.
        reg_write(REG_SLOT, 32'd8);
        queue_slot(8); queue_slot(8);
        @(negedge i_clk);
        hold_rx = 300;
        drain_all();

        // Random phases with varied settings.
        for (int ph = 0; ph < 13; ph++) begin
            slen = (ph != 3 && $urandom_range(0, 5) == 0) ? $urandom_range(33, 64)
                                                          : $urandom_range(1, 12);
            reg_write(REG_SLOT, slen);
            reg_write(REG_COEFF, $urandom_range(0, 31));
            reg_write(REG_NAVG, $urandom_range(0, 63));
            reg_write(REG_THRESH, 32'h1fff & (-2560 + $urandom_range(0, 2080)));
            for (int s = 0; s < (slen > 30 ? 1 : 50 / slen + 1); s++) begin
                queue_slot(slen);
                if (s == 1 && ph == 3) begin
                    // Sender pause until all results are in.
                    tx_pause = 1'b1;
                    while (s_axis_tvalid || result_queue.size() > 0) @(posedge i_clk);
                    tx_pause = 1'b0;
                end
            end
            drain_all();
        end

        if (err_count == 0) begin
            $display("beam_cell_measurement_filter_test: clean");
        end else begin
            $display("beam_cell_measurement_filter_test: errors");
        end
        $finish;
    end
endmodule
